FILE: rtl/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, sizes and codes of the subresource state table.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Table geometry.
  localparam int MAX_MIPS   = 16;
  localparam int MAX_SLICES = 64;
  localparam int MAX_PLANES = 4;
  localparam int STATE_BITS = 16;
  localparam int DEPTH      = MAX_MIPS * MAX_SLICES * MAX_PLANES;
  localparam int ADDR_W     = $clog2(DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_MIP_LEVELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_TOTAL = 2'd2;

  // Request types.
  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  // Response status codes.
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_MIXED = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  // One request.
  typedef struct packed {
    logic        req_type;
    logic [3:0]  base_mip;
    logic [4:0]  mip_count;
    logic [5:0]  base_slice;
    logic [6:0]  slice_count;
    logic [1:0]  base_plane;
    logic [2:0]  plane_count;
    logic [15:0] state_value;
  } sst_req_t;

  // One response.
  typedef struct packed {
    logic [15:0] state_out;
    logic [1:0]  status;
  } sst_rsp_t;

  // Effective texture dimensions after saturation.
  typedef struct packed {
    logic [4:0] m;
    logic [6:0] s;
    logic [2:0] p;
  } dims_t;

  // Command to the range walker.
  typedef struct packed {
    logic start;
  } walk_cmd_t;

  // Walker status: one table address per cycle while valid.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } walk_stat_t;

endpackage

FILE: rtl/sst_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_walk
// Range walker: works out the base address of a range in its multiply and add
// set-up states, then steps through every entry of the range, one address per cycle.
// ----------------------------------------------------------------------------
module sst_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  sst_pkg::walk_cmd_t  cmd,
  input  sst_pkg::sst_req_t   req,
  input  sst_pkg::dims_t      dims,
  output sst_pkg::walk_stat_t stat
);
  import sst_pkg::*;

  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_MUL  = 2'd1;
  localparam logic [1:0] W_ADD  = 2'd2;
  localparam logic [1:0] W_STEP = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [3:0]        bm_r, cm_m1_r, mi_r;
  logic [5:0]        bs_r, cs_m1_r, si_r;
  logic [1:0]        bp_r, cp_m1_r, pi_r;
  logic [ADDR_W-1:0] ms_r, bsm_r, addr_r, slice_start_r, plane_start_r;
  logic [ADDR_W-1:0] plane_off;
  logic              mi_end, si_end, pi_end;

  assign mi_end    = (mi_r == cm_m1_r);
  assign si_end    = (si_r == cs_m1_r);
  assign pi_end    = (pi_r == cp_m1_r);
  assign plane_off = ADDR_W'(ADDR_W'(bp_r) * ms_r);

  // Sequencing of set-up and walk.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      W_IDLE: begin
        if (cmd.start) begin
          state_nxt = W_MUL;
        end
      end
      W_MUL:  state_nxt = W_ADD;
      W_ADD:  state_nxt = W_STEP;
      W_STEP: begin
        if (mi_end && si_end && pi_end) begin
          state_nxt = W_IDLE;
        end
      end
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Range capture, base address and the three nested counters.
  always_ff @(posedge clk) begin
    case (state_r)
      W_IDLE: begin
        bm_r    <= req.base_mip;
        cm_m1_r <= 4'(req.mip_count - 5'd1);
        bs_r    <= req.base_slice;
        cs_m1_r <= 6'(req.slice_count - 7'd1);
        bp_r    <= req.base_plane;
        cp_m1_r <= 2'(req.plane_count - 3'd1);
      end
      W_MUL: begin
        ms_r  <= ADDR_W'(dims.m) * ADDR_W'(dims.s);
        bsm_r <= ADDR_W'(bs_r) * ADDR_W'(dims.m);
      end
      W_ADD: begin
        plane_start_r <= plane_off;
        slice_start_r <= plane_off + bsm_r;
        addr_r        <= plane_off + bsm_r + ADDR_W'(bm_r);
        mi_r          <= '0;
        si_r          <= '0;
        pi_r          <= '0;
      end
      W_STEP: begin
        if (!mi_end) begin
          mi_r   <= mi_r + 4'd1;
          addr_r <= addr_r + 1'b1;
        end else if (!si_end) begin
          mi_r          <= '0;
          si_r          <= si_r + 6'd1;
          slice_start_r <= slice_start_r + ADDR_W'(dims.m);
          addr_r        <= slice_start_r + ADDR_W'(dims.m) + ADDR_W'(bm_r);
        end else if (!pi_end) begin
          mi_r          <= '0;
          si_r          <= '0;
          pi_r          <= pi_r + 2'd1;
          plane_start_r <= plane_start_r + ms_r;
          slice_start_r <= plane_start_r + ms_r + bsm_r;
          addr_r        <= plane_start_r + ms_r + bsm_r + ADDR_W'(bm_r);
        end
      end
      default: begin
        mi_r <= mi_r;
      end
    endcase
  end

  assign stat.valid = (state_r == W_STEP);
  assign stat.last  = (state_r == W_STEP) && mi_end && si_end && pi_end;
  assign stat.addr  = addr_r;

  // A walk only begins from rest.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == W_MUL) |-> $past(cmd.start) && $past(state_r) == W_IDLE)
    else $error("walker set-up entered without a start");

  // The walk ends with its last address and then rests.
  a_last_rest: assert property (@(posedge clk) disable iff (!rst_n)
    stat.last |=> state_r == W_IDLE)
    else $error("walker kept stepping after its last address");

  // Counters never run past the range end.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.valid |-> mi_r <= cm_m1_r && si_r <= cs_m1_r && pi_r <= cp_m1_r)
    else $error("walker counter past range end");

endmodule

FILE: rtl/subresource_state_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subresource_state_table
// Per-subresource state codes kept in one 4096-entry memory. Stores write a
// code over a 3-D range, loads check the range for one uniform code.
// ----------------------------------------------------------------------------
// Timing: a flagged range answers in the cycle after start; a store answers
// after the walk's set-up and step states, a load after the read of its last entry.
// Throughput: one request at a time; the walk makes one memory access per
// cycle, so a request holds busy until its walk is through.
// Reset: a clearing pass writes zero to all 4096 entries, one per cycle,
// with busy high; configuration writes are taken throughout.
// The result strobe is one cycle wide and cannot be held off.
// ----------------------------------------------------------------------------
module subresource_state_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  sst_pkg::sst_req_t                   in_req,
  output logic                                out_valid,
  output sst_pkg::sst_rsp_t                   out_rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sst_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sst_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [4:0]            mip_levels_r;
  logic [6:0]            array_size_r;
  logic [2:0]            plane_total_r;
  dims_t                 dims;
  walk_cmd_t             walk_cmd;
  walk_stat_t            walk;
  logic                  range_ok;
  logic                  out_valid_r, out_valid_nxt;
  sst_rsp_t              out_rsp_r, out_rsp_nxt;
  logic                  is_store_r;
  logic [STATE_BITS-1:0] val_r;
  logic                  rd_pend_r, rd_last_r;
  logic                  first_r, mixed_r;
  logic [STATE_BITS-1:0] first_val_r, rd_data_r;
  logic                  mismatch, mixed_now, finish;
  logic [STATE_BITS-1:0] load_val;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [STATE_BITS-1:0] mem_wdata;
  logic [STATE_BITS-1:0] tbl_mem_r [DEPTH];

  // Configuration registers; the port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mip_levels_r  <= 5'd1;
      array_size_r  <= 7'd1;
      plane_total_r <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIP_LEVELS:  mip_levels_r  <= cfg_data[4:0];
        CFG_ARRAY_SIZE:  array_size_r  <= cfg_data[6:0];
        CFG_PLANE_TOTAL: plane_total_r <= cfg_data[2:0];
        default:         mip_levels_r  <= mip_levels_r;
      endcase
    end
  end

  // Effective dimensions, saturated at the table limits.
  assign dims.m = (mip_levels_r  > 5'(MAX_MIPS))   ? 5'(MAX_MIPS)   : mip_levels_r;
  assign dims.s = (array_size_r  > 7'(MAX_SLICES)) ? 7'(MAX_SLICES) : array_size_r;
  assign dims.p = (plane_total_r > 3'(MAX_PLANES)) ? 3'(MAX_PLANES) : plane_total_r;

  // Range check on every axis: a non-empty count that stays inside the texture.
  assign range_ok = (in_req.mip_count != '0) &&
                    (6'(in_req.base_mip) + 6'(in_req.mip_count) <= 6'(dims.m)) &&
                    (in_req.slice_count != '0) &&
                    (8'(in_req.base_slice) + 8'(in_req.slice_count) <= 8'(dims.s)) &&
                    (in_req.plane_count != '0) &&
                    (4'(in_req.base_plane) + 4'(in_req.plane_count) <= 4'(dims.p));

  sst_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (walk_cmd),
    .req   (in_req),
    .dims  (dims),
    .stat  (walk)
  );

  // Load comparison against the code at the range base.
  assign mismatch  = !first_r && (rd_data_r != first_val_r);
  assign mixed_now = mixed_r || mismatch;
  assign load_val  = first_r ? rd_data_r : first_val_r;
  assign finish    = is_store_r ? (walk.valid && walk.last) : (rd_pend_r && rd_last_r);

  // Request sequencing.
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    walk_cmd.start = 1'b0;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (!range_ok) begin
            out_valid_nxt         = 1'b1;
            out_rsp_nxt.state_out = '0;
            out_rsp_nxt.status    = STS_RANGE;
          end else begin
            walk_cmd.start = 1'b1;
            state_nxt      = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (finish) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (is_store_r) begin
            out_rsp_nxt.state_out = '0;
            out_rsp_nxt.status    = STS_OK;
          end else if (mixed_now) begin
            out_rsp_nxt.state_out = '0;
            out_rsp_nxt.status    = STS_MIXED;
          end else begin
            out_rsp_nxt.state_out = 16'(load_val);
            out_rsp_nxt.status    = STS_OK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= mem_re;
    end
  end

  // Request payload and comparison state.
  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
    rd_last_r <= walk.last;
    if (walk_cmd.start) begin
      is_store_r <= (in_req.req_type == REQ_STORE);
      val_r      <= STATE_BITS'(in_req.state_value);
      first_r    <= 1'b1;
      mixed_r    <= 1'b0;
    end else if (rd_pend_r) begin
      first_r <= 1'b0;
      mixed_r <= mixed_now;
      if (first_r) begin
        first_val_r <= rd_data_r;
      end
    end
  end

  // Memory port control: the clearing pass or the walk.
  assign mem_we    = (state_r == S_CLEAR) || ((state_r == S_RUN) && walk.valid && is_store_r);
  assign mem_re    = (state_r == S_RUN) && walk.valid && !is_store_r;
  assign mem_waddr = (state_r == S_CLEAR) ? clr_cnt_r : walk.addr;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : val_r;

  // State table, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= tbl_mem_r[walk.addr];
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // A load never writes the table.
  a_load_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && !is_store_r) |-> !mem_we)
    else $error("table written during a load");

  // Read data is only consumed in the cycle after a load's walk address.
  a_rd_follows: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(walk.valid) && !$past(is_store_r))
    else $error("read data without a preceding read");

  // Every finished walk produces a response.
  a_run_resp: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_RUN && state_r == S_IDLE) |-> out_valid_r)
    else $error("request finished without a response");

  // Mixed or flagged responses carry a zero state.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.status != STS_OK) |-> out_rsp_r.state_out == '0)
    else $error("error response with non-zero state");

  // No response appears while the table is being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r && !walk.valid)
    else $error("activity during the clearing pass");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subresource state table testbench
// Drives store and load requests through the command port and writes the
// texture dimensions through the configuration port. A local copy of the
// table predicts every response, which is checked field by field. A short
// directed part covers the corner cases, then random traffic follows.
// ----------------------------------------------------------------------------
module testbench;
  import sst_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned SLICE_CAP    = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  sst_req_t              in_req = '0;
  logic                  out_valid;
  sst_rsp_t              out_rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIP_LEVELS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the texture state and its dimension registers.
  logic [STATE_BITS-1:0] state_tbl [DEPTH];
  logic [4:0]            reg_mips = 5'd1;
  logic [6:0]            reg_slices = 7'd1;
  logic [2:0]            reg_planes = 3'd1;

  // Responses still owed by the block, oldest first.
  sst_rsp_t              rsp_q [$];
  sst_rsp_t              rsp_want;
  int unsigned           err_cnt = 0;
  int unsigned           rsp_seen = 0;
  int unsigned           items_sent = 0;
  int unsigned           burst_left = 0;

  subresource_state_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      state_tbl[i] = '0;
    end
  end

  // Only the first ten failures are shown; the rest are counted.
  function automatic void note_fail(input string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int unsigned dim_mips();
    return clamp_dim(reg_mips, MAX_MIPS);
  endfunction

  function automatic int unsigned dim_slices();
    return clamp_dim(reg_slices, MAX_SLICES);
  endfunction

  function automatic int unsigned dim_planes();
    return clamp_dim(reg_planes, MAX_PLANES);
  endfunction

  function automatic bit texture_ok();
    return dim_mips() != 0 && dim_slices() != 0 && dim_planes() != 0;
  endfunction

  function automatic bit axis_fits(input int unsigned base, input int unsigned count,
                                   input int unsigned dim);
    return count != 0 && base + count <= dim;
  endfunction

  // Applies one request to the local table and returns the response it owes.
  function automatic sst_rsp_t apply_request(input sst_req_t r);
    sst_rsp_t              rsp;
    int unsigned           m, s, p, bm, bs, bp, mi, si, pi, idx;
    logic [STATE_BITS-1:0] base_code;
    bit                    mixed;
    m     = dim_mips();
    s     = dim_slices();
    p     = dim_planes();
    bm    = r.base_mip;
    bs    = r.base_slice;
    bp    = r.base_plane;
    rsp   = '0;
    mixed = 1'b0;
    if (!axis_fits(bm, r.mip_count, m) || !axis_fits(bs, r.slice_count, s) ||
        !axis_fits(bp, r.plane_count, p)) begin
      rsp.status = STS_RANGE;
    end else begin
      base_code = state_tbl[bp * m * s + bs * m + bm];
      for (pi = bp; pi < bp + r.plane_count; pi++) begin
        for (si = bs; si < bs + r.slice_count; si++) begin
          for (mi = bm; mi < bm + r.mip_count; mi++) begin
            idx = pi * m * s + si * m + mi;
            if (r.req_type == REQ_STORE) begin
              state_tbl[idx] = r.state_value;
            end else if (state_tbl[idx] != base_code) begin
              mixed = 1'b1;
            end
          end
        end
      end
      if (r.req_type == REQ_LOAD) begin
        if (mixed) begin
          rsp.status = STS_MIXED;
        end else begin
          rsp.state_out = base_code;
        end
      end
    end
    return rsp;
  endfunction

  function automatic sst_req_t mk_req(input logic kind, input logic [3:0] bm,
                                      input logic [4:0] cm, input logic [5:0] bs,
                                      input logic [6:0] cs, input logic [1:0] bp,
                                      input logic [2:0] cp, input logic [15:0] val);
    sst_req_t r;
    r.req_type    = kind;
    r.base_mip    = bm;
    r.mip_count   = cm;
    r.base_slice  = bs;
    r.slice_count = cs;
    r.base_plane  = bp;
    r.plane_count = cp;
    r.state_value = val;
    return r;
  endfunction

  // A request with every field random; mostly outside the texture.
  function automatic sst_req_t noise_req();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(sst_req_t)-1:0];
  endfunction

  // A range inside the texture; the slice extent is capped to keep walks short.
  function automatic sst_req_t any_range(input logic kind);
    sst_req_t    r;
    int unsigned room;
    r             = '0;
    r.req_type    = kind;
    r.state_value = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    r.base_mip    = 4'($urandom_range(0, dim_mips() - 1));
    r.mip_count   = 5'($urandom_range(1, dim_mips() - r.base_mip));
    r.base_slice  = 6'($urandom_range(0, dim_slices() - 1));
    room          = clamp_dim(dim_slices() - r.base_slice, SLICE_CAP);
    r.slice_count = 7'($urandom_range(1, room));
    r.base_plane  = 2'($urandom_range(0, dim_planes() - 1));
    r.plane_count = 3'($urandom_range(1, dim_planes() - r.base_plane));
    return r;
  endfunction

  // A load over part of an earlier range, so it usually sees one code.
  function automatic sst_req_t inner_range(input sst_req_t r);
    sst_req_t    q;
    int unsigned off;
    q             = r;
    q.req_type    = REQ_LOAD;
    q.state_value = 16'($urandom);
    off           = $urandom_range(0, r.mip_count - 1);
    q.base_mip    = 4'(r.base_mip + off);
    q.mip_count   = 5'($urandom_range(1, r.mip_count - off));
    off           = $urandom_range(0, r.slice_count - 1);
    q.base_slice  = 6'(r.base_slice + off);
    q.slice_count = 7'($urandom_range(1, r.slice_count - off));
    off           = $urandom_range(0, r.plane_count - 1);
    q.base_plane  = 2'(r.base_plane + off);
    q.plane_count = 3'($urandom_range(1, r.plane_count - off));
    return q;
  endfunction

  // Presents one request and waits for it to be taken; start is left high.
  task automatic send_req(input sst_req_t r);
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    rsp_q.push_back(apply_request(r));
    items_sent++;
  endtask

  // The sender works in bursts with random gaps, some after the block goes idle.
  task automatic issue(input sst_req_t r);
    if (burst_left == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        while (busy !== 1'b0) @(posedge clk);
      end
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
    end
    burst_left--;
    send_req(r);
  endtask

  // Holds off new requests until every response is in and the block is idle.
  task automatic drain();
    start <= 1'b0;
    while (rsp_q.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_MIP_LEVELS:  reg_mips   = data[4:0];
      CFG_ARRAY_SIZE:  reg_slices = data[6:0];
      CFG_PLANE_TOTAL: reg_planes = data[2:0];
      default: ;
    endcase
  endtask

  task automatic set_texture(input logic [6:0] mips, input logic [6:0] slices,
                             input logic [6:0] planes);
    drain();
    write_reg(CFG_MIP_LEVELS, mips);
    write_reg(CFG_ARRAY_SIZE, slices);
    write_reg(CFG_PLANE_TOTAL, planes);
    cfg_valid <= 1'b0;
  endtask

  // The table must come out of reset cleared; the load ignores its value field.
  task automatic test_after_reset();
    issue(mk_req(REQ_LOAD,  0, 1, 0, 1, 0, 1, 16'hFFFF));
    issue(mk_req(REQ_STORE, 0, 1, 0, 1, 0, 1, 16'hFFFF));
    issue(mk_req(REQ_LOAD,  0, 1, 0, 1, 0, 1, 16'h0000));
  endtask

  // Empty and overrunning ranges are flagged and leave the table alone.
  task automatic test_range_flags();
    issue(mk_req(REQ_LOAD,  0, 0, 0, 1, 0, 1, 16'h0000));
    issue(mk_req(REQ_STORE, 0, 1, 0, 0, 0, 1, 16'h1111));
    issue(mk_req(REQ_STORE, 0, 1, 0, 1, 0, 0, 16'h2222));
    issue(mk_req(REQ_STORE, 4'hF, 5'h1F, 6'h3F, 7'h7F, 2'h3, 3'h7, 16'hFFFF));
    issue(mk_req(REQ_STORE, 0, 2, 0, 1, 0, 1, 16'h3333));
    issue(mk_req(REQ_LOAD,  0, 1, 0, 1, 0, 1, 16'h5555));
  endtask

  // Register values above the maximum saturate; the whole table is walked.
  task automatic test_max_texture();
    set_texture(7'h7F, 7'h7F, 7'h07);
    issue(mk_req(REQ_STORE, 0, 16, 0, 64, 0, 4, 16'hA5A5));
    issue(mk_req(REQ_LOAD,  0, 16, 0, 64, 0, 4, 16'h0000));
    issue(mk_req(REQ_STORE, 15, 1, 63, 1, 3, 1, 16'h0000));
    issue(mk_req(REQ_LOAD,  0, 16, 0, 64, 0, 4, 16'hFFFF));
    issue(mk_req(REQ_LOAD,  15, 1, 63, 1, 3, 1, 16'h8001));
    issue(mk_req(REQ_STORE, 0, 16, 0, 64, 1, 4, 16'h0F0F));
  endtask

  // Entries stay where they are when the dimensions change; only indexing moves.
  task automatic test_config_change();
    set_texture(7'd4, 7'd2, 7'd1);
    issue(mk_req(REQ_LOAD,  0, 4, 0, 2, 0, 1, 16'h0000));
    issue(mk_req(REQ_STORE, 1, 2, 0, 1, 0, 1, 16'h1234));
    issue(mk_req(REQ_LOAD,  0, 4, 0, 2, 0, 1, 16'h0000));
    issue(mk_req(REQ_LOAD,  1, 2, 0, 1, 0, 1, 16'hFFFF));
  endtask

  // A zero in any dimension register empties the texture.
  task automatic test_empty_texture();
    set_texture(7'd0, 7'd1, 7'd1);
    issue(mk_req(REQ_LOAD,  0, 1, 0, 1, 0, 1, 16'h0000));
    set_texture(7'd1, 7'd0, 7'd1);
    issue(mk_req(REQ_STORE, 0, 1, 0, 1, 0, 1, 16'h7777));
    set_texture(7'd1, 7'd1, 7'd0);
    issue(mk_req(REQ_LOAD,  0, 1, 0, 1, 0, 1, 16'h0000));
    set_texture(7'd1, 7'd1, 7'd1);
    issue(mk_req(REQ_LOAD,  0, 1, 0, 1, 0, 1, 16'h0000));
  endtask

  // Mostly a store followed by loads over the same or nearby ranges.
  task automatic random_step();
    sst_req_t    r;
    int unsigned k;
    k = $urandom_range(0, 19);
    if (!texture_ok() || k < 3) begin
      issue(noise_req());
    end else if (k < 8) begin
      issue(any_range($urandom_range(0, 1) ? REQ_LOAD : REQ_STORE));
    end else begin
      r = any_range(REQ_STORE);
      issue(r);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0:       issue(inner_range(r));
          1:       issue(mk_req(REQ_LOAD, r.base_mip, r.mip_count, r.base_slice,
                                r.slice_count, r.base_plane, r.plane_count,
                                16'($urandom)));
          default: issue(any_range(REQ_LOAD));
        endcase
      end
    end
  endtask

  // Random traffic in phases, each with its own texture dimensions.
  task automatic test_random_traffic();
    int unsigned target, phase_end, sel;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        set_texture(7'd16, 7'd64, 7'd4);
      end else if (sel == 1) begin
        set_texture(7'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 7)));
      end else begin
        set_texture(7'($urandom_range(1, 16)), 7'($urandom_range(1, 8)),
                    7'($urandom_range(1, 4)));
      end
      phase_end = items_sent + $urandom_range(80, 250);
      while (items_sent < phase_end && items_sent < target) begin
        random_step();
      end
    end
  endtask

  // Response checker: the receiver cannot stall, so every strobe is taken.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      rsp_seen++;
      if (rsp_q.size() == 0) begin
        note_fail($sformatf("response %0d with none pending: state_out=%h status=%0d",
                            rsp_seen, out_rsp.state_out, out_rsp.status));
      end else begin
        rsp_want = rsp_q.pop_front();
        if (out_rsp.state_out !== rsp_want.state_out) begin
          note_fail($sformatf("response %0d state_out: expected %h, got %h",
                              rsp_seen, rsp_want.state_out, out_rsp.state_out));
        end
        if (out_rsp.status !== rsp_want.status) begin
          note_fail($sformatf("response %0d status: expected %0d, got %0d",
                              rsp_seen, rsp_want.status, out_rsp.status));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_range_flags();
    test_max_texture();
    test_config_change();
    test_empty_texture();
    test_random_traffic();
    start <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && rsp_q.size() != 0; i++) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
    if (rsp_q.size() != 0) begin
      note_fail($sformatf("%0d responses never arrived", rsp_q.size()));
    end
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit, well above the slowest legal run.
  initial begin
    #(1_000_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
